>>> src/aagl_pkg.sv
// ----------------------------------------------------------------------------
// aagl_pkg: shared constants and types of the antialiased line raster
// Line modes, record kinds, register indexes and helper widths.
// ----------------------------------------------------------------------------
package aagl_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_XMAJ = 3'd1;
   localparam logic [2:0] MODE_YMAJ = 3'd2;
   localparam logic [2:0] MODE_HORZ = 3'd3;
   localparam logic [2:0] MODE_VERT = 3'd4;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
   localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
   localparam logic [1:0] REG_CLIP_WIDTH  = 2'd2;
   localparam logic [1:0] REG_CLIP_HEIGHT = 2'd3;

   localparam logic [15:0] CLIP_SIZE_RESET = 16'hFFFF;

   // fraction width of the colour and slope quotients
   localparam int FRAC_BITS = 16;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // classified item: kind, mode, horz, dir_neg, x1, y1, x2, y2, dx, dy,
   // lo, span, other, start colour, end colour
   function automatic int rec_width(input int c);
      rec_width = 6 + 6 * c + 3 * (c + 1) + 64;
   endfunction

endpackage

>>> src/aagl_queue.sv
// ----------------------------------------------------------------------------
// aagl_queue: small register queue between front and back
// Holds classified words; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module aagl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = aagl_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/aagl_front.sv
// ----------------------------------------------------------------------------
// aagl_front: clip registers and item classification
// Orders endpoints by y, finds deltas, mode and the clipped axis span.
// ----------------------------------------------------------------------------
module aagl_front #(
   parameter int COORD_BITS = aagl_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata,
   input  logic                  action,
   input  logic [COORD_BITS-1:0] start_x,
   input  logic [COORD_BITS-1:0] start_y,
   input  logic [COORD_BITS-1:0] end_x,
   input  logic [COORD_BITS-1:0] end_y,
   input  logic [31:0]           start_color,
   input  logic [31:0]           end_color,
   output logic [aagl_pkg::rec_width(COORD_BITS)-1:0] rec
);
   localparam int C  = COORD_BITS;
   localparam int D  = C + 1;
   localparam int EW = ((C > 16) ? C : 16) + 3;

   logic [15:0] clip_left_ff, clip_top_ff, clip_width_ff, clip_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_width_ff  <= aagl_pkg::CLIP_SIZE_RESET;
         clip_height_ff <= aagl_pkg::CLIP_SIZE_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            aagl_pkg::REG_CLIP_LEFT:   clip_left_ff   <= csr_wdata;
            aagl_pkg::REG_CLIP_TOP:    clip_top_ff    <= csr_wdata;
            aagl_pkg::REG_CLIP_WIDTH:  clip_width_ff  <= csr_wdata;
            aagl_pkg::REG_CLIP_HEIGHT: clip_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic                swap, horz, vert, dir_neg, empty;
   logic [C-1:0]        x1, y1, x2, y2, a, b, other;
   logic signed [D-1:0] xdiff;
   logic [D-1:0]        dx, dy, span;
   logic signed [EW-1:0] a_e, b_e, lc, t, lo, hi;
   logic [EW-1:0]       size;
   logic [2:0]          mode;

   always_comb begin
      swap    = $signed(start_y) > $signed(end_y);
      x1      = swap ? end_x : start_x;
      y1      = swap ? end_y : start_y;
      x2      = swap ? start_x : end_x;
      y2      = swap ? start_y : end_y;
      horz    = (y1 == y2);
      vert    = !horz && (x1 == x2);
      dir_neg = $signed(x2) < $signed(x1);
      xdiff   = $signed({x2[C-1], x2}) - $signed({x1[C-1], x1});
      dx      = dir_neg ? D'(-xdiff) : D'(xdiff);
      dy      = D'($signed({y2[C-1], y2}) - $signed({y1[C-1], y1}));

      // axis span, clipped on its own axis only
      if (horz) begin
         a     = dir_neg ? x2 : x1;
         b     = dir_neg ? x1 : x2;
         other = y1;
         lc    = EW'($signed(clip_left_ff));
         size  = EW'(clip_width_ff);
      end else begin
         a     = y1;
         b     = y2;
         other = x1;
         lc    = EW'($signed(clip_top_ff));
         size  = EW'(clip_height_ff);
      end
      a_e   = EW'($signed(a));
      b_e   = EW'($signed(b));
      t     = lc + $signed(size) - EW'(1);
      lo    = (a_e > lc) ? a_e : lc;
      hi    = (b_e < t) ? b_e : t;
      empty = hi < lo;
      span  = D'(hi - lo);

      if (horz) begin
         mode = empty ? aagl_pkg::MODE_IDLE : aagl_pkg::MODE_HORZ;
      end else if (vert) begin
         mode = empty ? aagl_pkg::MODE_IDLE : aagl_pkg::MODE_VERT;
      end else begin
         mode = (dy > dx) ? aagl_pkg::MODE_YMAJ : aagl_pkg::MODE_XMAJ;
      end

      rec = {action, mode, horz, dir_neg, x1, y1, x2, y2, dx, dy,
             C'(lo), span, other, start_color, end_color};
   end

endmodule

>>> src/aagl_div.sv
// ----------------------------------------------------------------------------
// aagl_div: radix-2 fraction divider
// Returns (num << 16) / den for num <= den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aagl_div #(
   parameter int WIDTH = 18
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [WIDTH-1:0]       num,
   input  logic [WIDTH-1:0]       den,
   output aagl_pkg::div_stat_type stat,
   output logic [aagl_pkg::FRAC_BITS:0] quot
);
   localparam int QB = aagl_pkg::FRAC_BITS;
   localparam int CW = $clog2(QB);

   logic             busy_ff, busy_in, done_ff, done_in, zero_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in, den_ff;
   logic [QB:0]      q_ff, q_in;
   logic [WIDTH:0]   rem2;
   logic             ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      rem2    = {rem_ff, 1'b0};
      ge      = rem2 >= {1'b0, den_ff};
      if (start) begin
         // integer bit first; it is 1 only when num equals den
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = {{QB{1'b0}}, (num >= den)};
         rem_in  = (num >= den) ? num - den : num;
      end else if (busy_ff) begin
         q_in   = {q_ff[QB-1:0], ge};
         rem_in = ge ? WIDTH'(rem2 - {1'b0, den_ff}) : WIDTH'(rem2);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (start) begin
         den_ff  <= den;
         zero_ff <= (den == '0);
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = zero_ff ? '0 : q_ff;

endmodule

>>> src/aagl_back.sv
// ----------------------------------------------------------------------------
// aagl_back: line sequencer
// Runs setup (length root, slope divide), steps and the output register.
// ----------------------------------------------------------------------------
module aagl_back #(
   parameter int COORD_BITS = aagl_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  logic [aagl_pkg::rec_width(COORD_BITS)-1:0] q_data,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [COORD_BITS-1:0] pixel_x,
   output logic [COORD_BITS-1:0] pixel_y,
   output logic [31:0]           pixel_color,
   output logic [7:0]            coverage,
   output logic                  last_pixel
);
   localparam int C  = COORD_BITS;
   localparam int D  = C + 1;
   localparam int L  = C + 2;
   localparam int NW = 2 * D + 4;
   localparam int RB = D + 2;           // root bits
   localparam int RW = D + 4;           // root remainder bits
   localparam int ROOT_STEPS = NW / 2;
   localparam int KW = $clog2(ROOT_STEPS + 1);
   localparam int QB = aagl_pkg::FRAC_BITS;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FIRST = 4'd1;
   localparam logic [3:0] ST_SQX   = 4'd2;
   localparam logic [3:0] ST_SQY   = 4'd3;
   localparam logic [3:0] ST_ROOT  = 4'd4;
   localparam logic [3:0] ST_EDIV  = 4'd5;
   localparam logic [3:0] ST_CDIV  = 4'd6;
   localparam logic [3:0] ST_MIX   = 4'd7;
   localparam logic [3:0] ST_PUT0  = 4'd8;
   localparam logic [3:0] ST_PUT1  = 4'd9;
   localparam logic [3:0] ST_LASTP = 4'd10;
   localparam logic [3:0] ST_APUT  = 4'd11;

   // unpack the classified word
   logic         r_kind, r_horz, r_dir;
   logic [2:0]   r_mode;
   logic [C-1:0] r_x1, r_y1, r_x2, r_y2, r_lo, r_other;
   logic [D-1:0] r_dx, r_dy, r_span;
   logic [31:0]  r_cfrom, r_cto;

   assign {r_kind, r_mode, r_horz, r_dir, r_x1, r_y1, r_x2, r_y2, r_dx, r_dy,
           r_lo, r_span, r_other, r_cfrom, r_cto} = q_data;

   logic [3:0]    state_ff, state_in;
   logic [2:0]    mode_ff, mode_in;
   logic          horz_ff, horz_in, dir_ff, dir_in, plast_ff, plast_in;
   logic [C-1:0]  major_ff, major_in, minor_ff, minor_in, mnext_ff, mnext_in;
   logic [C-1:0]  tx_ff, tx_in, ty_ff, ty_in;
   logic [31:0]   acc_ff, acc_in, estep_ff, estep_in;
   logic [D-1:0]  steps_ff, steps_in, pidx_ff, pidx_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [L-1:0]  invlen_ff, invlen_in;
   logic [31:0]   cfrom_ff, cfrom_in, cto_ff, cto_in, color_ff, color_in;
   logic [NW-3:0] sum_ff, sum_in;
   logic [NW-1:0] rad_ff, rad_in;
   logic [RW-1:0] rem_ff, rem_in, rem_sh, trial;
   logic [RB-1:0] root_ff, root_in, root_new;
   logic [KW-1:0] cnt_ff, cnt_in;

   logic          div_start;
   logic [L-1:0]  div_num, div_den;
   aagl_pkg::div_stat_type div_stat;
   logic [QB:0]   div_quot;

   aagl_div #(.WIDTH(L)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // output register
   logic          out_valid_ff, can_put, put_en, put_last;
   logic [C-1:0]  put_x, put_y;
   logic [31:0]   put_c;
   logic [7:0]    put_cov, w;

   assign can_put = !out_valid_ff || rsp_tready;
   assign w       = acc_ff[31:24];

   logic [2*D-1:0] prod;
   logic [31:0]    mix;
   logic [QB:0]    gf;
   logic [QB+9:0]  chan;
   logic           ymaj, adv;
   logic [31:0]    acc_new;
   logic [C-1:0]   dirv;

   assign prod = (state_ff == ST_SQX) ? dx_ff * dx_ff : dy_ff * dy_ff;

   always_comb begin
      gf  = {1'b1, {QB{1'b0}}} - div_quot;
      mix = '0;
      for (int s = 0; s < 4; s++) begin
         chan = (QB + 10)'(cfrom_ff[8*s +: 8] * gf) + (QB + 10)'(cto_ff[8*s +: 8] * div_quot);
         mix[8*s +: 8] = chan[QB +: 8];
      end
   end

   always_comb begin
      rem_sh   = {rem_ff[RW-3:0], rad_ff[NW-1 -: 2]};
      trial    = {root_ff, 2'b01};
      root_new = (rem_sh >= trial) ? {root_ff[RB-2:0], 1'b1} : {root_ff[RB-2:0], 1'b0};
   end

   always_comb begin
      state_in = state_ff;  mode_in  = mode_ff;   horz_in  = horz_ff;
      dir_in   = dir_ff;    plast_in = plast_ff;  major_in = major_ff;
      minor_in = minor_ff;  mnext_in = mnext_ff;  tx_in    = tx_ff;
      ty_in    = ty_ff;     acc_in   = acc_ff;    estep_in = estep_ff;
      steps_in = steps_ff;  pidx_in  = pidx_ff;   dx_in    = dx_ff;
      dy_in    = dy_ff;     invlen_in = invlen_ff; cfrom_in = cfrom_ff;
      cto_in   = cto_ff;    color_in = color_ff;  sum_in   = sum_ff;
      rad_in   = rad_ff;    rem_in   = rem_ff;    root_in  = root_ff;
      cnt_in   = cnt_ff;
      q_pop     = 1'b0;
      div_start = 1'b0;
      div_num   = L'(pidx_ff);
      div_den   = invlen_ff;
      put_en    = 1'b0;
      put_x     = major_ff;
      put_y     = minor_ff;
      put_c     = color_ff;
      put_cov   = 8'hFF;
      put_last  = 1'b0;
      ymaj      = (mode_ff == aagl_pkg::MODE_YMAJ);
      dirv      = dir_ff ? '1 : C'(1);
      acc_new   = acc_ff + estep_ff;
      adv       = acc_new <= acc_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (r_kind == aagl_pkg::KIND_START) begin
                  cfrom_in = r_cfrom;
                  cto_in   = r_cto;
                  horz_in  = r_horz;
                  pidx_in  = '0;
                  if (r_mode == aagl_pkg::MODE_IDLE) begin
                     mode_in = aagl_pkg::MODE_IDLE;   // clipped away
                  end else if (r_mode == aagl_pkg::MODE_HORZ ||
                               r_mode == aagl_pkg::MODE_VERT) begin
                     major_in  = r_lo;
                     minor_in  = r_other;
                     invlen_in = L'(r_span);
                     steps_in  = r_span;
                     mode_in   = (r_span != '0) ? r_mode : aagl_pkg::MODE_IDLE;
                     color_in  = r_cfrom;
                     plast_in  = (r_span == '0);
                     state_in  = ST_APUT;
                  end else begin
                     mode_in = r_mode;
                     dir_in  = r_dir;
                     tx_in   = r_x2;
                     ty_in   = r_y2;
                     acc_in  = '0;
                     dx_in   = r_dx;
                     dy_in   = r_dy;
                     if (r_mode == aagl_pkg::MODE_YMAJ) begin
                        major_in = r_y1;
                        minor_in = r_x1;
                        mnext_in = r_x1 + (r_dir ? '1 : C'(1));
                        steps_in = r_dy - 1'b1;
                     end else begin
                        major_in = r_x1;
                        minor_in = r_y1;
                        mnext_in = r_y1 + C'(1);
                        steps_in = r_dx - 1'b1;
                     end
                     state_in = ST_FIRST;
                  end
               end else if (mode_ff == aagl_pkg::MODE_XMAJ || ymaj) begin
                  if (steps_ff == '0) begin
                     mode_in  = aagl_pkg::MODE_IDLE;
                     state_in = ST_LASTP;
                  end else begin
                     acc_in = acc_new;
                     if (adv) begin
                        minor_in = mnext_ff;
                        mnext_in = mnext_ff + (ymaj ? dirv : C'(1));
                     end
                     major_in  = major_ff + (ymaj ? C'(1) : dirv);
                     div_start = 1'b1;             // colour at old index
                     pidx_in   = pidx_ff + 1'b1;
                     steps_in  = steps_ff - 1'b1;
                     state_in  = ST_CDIV;
                  end
               end else if ((mode_ff == aagl_pkg::MODE_HORZ ||
                             mode_ff == aagl_pkg::MODE_VERT) && steps_ff != '0) begin
                  pidx_in   = pidx_ff + 1'b1;
                  major_in  = major_ff + C'(1);
                  steps_in  = steps_ff - 1'b1;
                  plast_in  = (steps_ff == D'(1));
                  if (steps_ff == D'(1)) begin
                     mode_in = aagl_pkg::MODE_IDLE;
                  end
                  div_start = 1'b1;
                  div_num   = L'(pidx_ff + 1'b1);
                  state_in  = ST_CDIV;
               end else begin
                  mode_in = aagl_pkg::MODE_IDLE;
               end
            end
         end
         ST_FIRST: begin
            put_x   = ymaj ? minor_ff : major_ff;
            put_y   = ymaj ? major_ff : minor_ff;
            put_c   = cfrom_ff;
            put_en  = can_put;
            if (can_put) begin
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            sum_in   = (NW - 2)'(prod);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            rad_in   = {sum_ff + (NW - 2)'(prod), 2'b00};
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rem_in  = (rem_sh >= trial) ? rem_sh - trial : rem_sh;
            root_in = root_new;
            rad_in  = {rad_ff[NW-3:0], 2'b00};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == KW'(ROOT_STEPS - 1)) begin
               invlen_in = L'(({1'b0, root_new} + 1'b1) >> 1);
               div_start = 1'b1;
               div_num   = ymaj ? L'(dx_ff) : L'(dy_ff);
               div_den   = ymaj ? L'(dy_ff) : L'(dx_ff);
               state_in  = ST_EDIV;
            end
         end
         ST_EDIV: begin
            if (div_stat.done) begin
               estep_in = {div_quot[QB-1:0], {QB{1'b0}}};
               state_in = ST_IDLE;
            end
         end
         ST_CDIV: begin
            if (div_stat.done) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            color_in = mix;
            state_in = (mode_ff == aagl_pkg::MODE_XMAJ || ymaj) ? ST_PUT0 : ST_APUT;
         end
         ST_PUT0: begin
            put_x   = ymaj ? minor_ff : major_ff;
            put_y   = ymaj ? major_ff : minor_ff;
            put_cov = 8'hFF - w;
            put_en  = can_put;
            if (can_put) begin
               state_in = ST_PUT1;
            end
         end
         ST_PUT1: begin
            put_x   = ymaj ? mnext_ff : major_ff;
            put_y   = ymaj ? major_ff : mnext_ff;
            put_cov = w;
            put_en  = can_put;
            if (can_put) begin
               state_in = ST_IDLE;
            end
         end
         ST_LASTP: begin
            put_x    = tx_ff;
            put_y    = ty_ff;
            put_c    = cto_ff;
            put_last = 1'b1;
            put_en   = can_put;
            if (can_put) begin
               state_in = ST_IDLE;
            end
         end
         ST_APUT: begin
            put_x    = horz_ff ? major_ff : minor_ff;
            put_y    = horz_ff ? minor_ff : major_ff;
            put_last = plast_ff;
            put_en   = can_put;
            if (can_put) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= aagl_pkg::MODE_IDLE;
         out_valid_ff <= 1'b0;
         horz_ff  <= 1'b0;  dir_ff   <= 1'b0;  plast_ff <= 1'b0;
         major_ff <= '0;    minor_ff <= '0;    mnext_ff <= '0;
         tx_ff    <= '0;    ty_ff    <= '0;    acc_ff   <= '0;
         estep_ff <= '0;    steps_ff <= '0;    pidx_ff  <= '0;
         invlen_ff <= '0;   cfrom_ff <= '0;    cto_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         if (put_en) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         horz_ff  <= horz_in;  dir_ff   <= dir_in;   plast_ff <= plast_in;
         major_ff <= major_in; minor_ff <= minor_in; mnext_ff <= mnext_in;
         tx_ff    <= tx_in;    ty_ff    <= ty_in;    acc_ff   <= acc_in;
         estep_ff <= estep_in; steps_ff <= steps_in; pidx_ff  <= pidx_in;
         invlen_ff <= invlen_in; cfrom_ff <= cfrom_in; cto_ff <= cto_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      color_ff <= color_in;
      sum_ff   <= sum_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      if (put_en) begin
         pixel_x     <= put_x;
         pixel_y     <= put_y;
         pixel_color <= put_c;
         coverage    <= put_cov;
         last_pixel  <= put_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE))
      else $error("queue popped outside idle");
   a_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT1) |-> ($past(state_ff) == ST_PUT0 || $past(state_ff) == ST_PUT1))
      else $error("second pixel of a pair without the first");

endmodule

>>> src/antialiased_gradient_line_raster.sv
// ----------------------------------------------------------------------------
// antialiased_gradient_line_raster: Wu-style line raster with colour gradient
// Start words load a line and give its first pixel unless clipped away; step
// words give the next pixel pair or end pixel (sloped), pixel (axis, clipped).
// ----------------------------------------------------------------------------
//  channel | dir | words
//  req_*   | in  | start (tuser 0) or step (tuser 1) words
//  rsp_*   | out | pixels, tlast on the final pixel of a line
//  csr_*   | in  | clip register writes, no wait
//
//  Sloped start: pop, first pixel, then setup (two squares on one multiplier,
//  a COORD_BITS + 3 step root, the slope divide). Axis start: pop, then the
//  first pixel; a clipped-away start or an idle step is only popped.
//  Step: pop, colour divide, mix, two pixels (sloped) or one (axis-aligned);
//  the final sloped step gives the end pixel. Output stalls add cycles.
//  Reset: synchronous, all control cleared, clip to 0/0/65535/65535.
//  Front and back decouple through a two-word queue; a stalled output register
//  holds the back, the queue fills and req_tready drops.
// ----------------------------------------------------------------------------
module antialiased_gradient_line_raster #(
   parameter int COORD_BITS = aagl_pkg::COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // config write port
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // action
   // start_x, start_y, end_x, end_y, start_color, end_color (low bit up)
   input  logic [((4*COORD_BITS+64+7)/8)*8-1:0] req_tdata,
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tlast,   // last_pixel
   // pixel_x, pixel_y, pixel_color, coverage (low bit up)
   output logic [((2*COORD_BITS+40+7)/8)*8-1:0] rsp_tdata
);
   localparam int C     = COORD_BITS;
   localparam int REC_W = aagl_pkg::rec_width(COORD_BITS);
   localparam int OW    = ((2 * C + 40 + 7) / 8) * 8;

   logic [REC_W-1:0] rec, q_data;
   logic             q_full, q_valid, q_pop, push;

   logic [C-1:0] pixel_x, pixel_y;
   logic [31:0]  pixel_color;
   logic [7:0]   coverage;

   assign req_tready = !q_full;
   assign push       = req_tvalid && req_tready;

   aagl_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .action      (req_tuser),
      .start_x     (req_tdata[C-1:0]),
      .start_y     (req_tdata[2*C-1:C]),
      .end_x       (req_tdata[3*C-1:2*C]),
      .end_y       (req_tdata[4*C-1:3*C]),
      .start_color (req_tdata[4*C+31:4*C]),
      .end_color   (req_tdata[4*C+63:4*C+32]),
      .rec         (rec)
   );

   aagl_queue #(.WIDTH(REC_W), .DEPTH(aagl_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (rec),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_data)
   );

   aagl_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .pixel_color (pixel_color),
      .coverage    (coverage),
      .last_pixel  (rsp_tlast)
   );

   assign rsp_tdata = OW'({coverage, pixel_color, pixel_y, pixel_x});

endmodule

>>> tb/sv/tb_antialiased_gradient_line_raster.sv
// ----------------------------------------------------------------------------
// tb_antialiased_gradient_line_raster: self-checking bench of the line raster
// Drives start and step words with random gaps and output stalls, predicts
// the pixels with a behavioral copy of the raster and compares in order.
// ----------------------------------------------------------------------------
module tb_antialiased_gradient_line_raster;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = 16;
   localparam int REQ_W = ((4*CB+64+7)/8)*8;
   localparam int RSP_W = ((2*CB+40+7)/8)*8;
   localparam int WATCHDOG = 20000;
   localparam int TAIL = 200;

   typedef struct packed {
      logic [15:0] px;
      logic [15:0] py;
      logic [31:0] color;
      logic [7:0]  cov;
      logic        last;
   } pixel_type;

   typedef struct {
      logic        act;
      logic [15:0] sx, sy, ex, ey;
      logic [31:0] sc, ec;
      int          n_known; // 0: use predictor, else p0 replaces the last predicted pixel
      pixel_type   p0;
   } stim_type;

   logic clock = 0, reset = 1;
   logic csr_wen = 0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic req_tvalid = 0, req_tuser = 0;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tready;
   logic rsp_tvalid, rsp_tlast;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   antialiased_gradient_line_raster u_top (.*);

   // ---- predictor state (widened, masked on output)
   longint clip_l, clip_t, clip_w, clip_h;
   logic [2:0] mode;
   longint maj, mnr, mnr_nx, tgt_x, tgt_y, steps, pidx, inv_len;
   bit dir_neg;
   logic [31:0] err_acc, err_step, col_a, col_b;

   pixel_type pixel_queue[$];
   int errors = 0;
   int send_idle = 0, recv_idle = 0; // percent
   int quiet = 0;

   function automatic longint sx16(logic [15:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint isqrt(longint unsigned n);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else
            r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] blend(longint k, longint d);
      longint unsigned f = 0, a, b, c;
      logic [31:0] res = '0;
      if (d != 0) begin
         f = (longint'(k) << 16) / d;
         if (f > 65536) f = 65536;
      end
      for (int s = 0; s < 32; s += 8) begin
         a = (col_a >> s) & 8'hFF;
         b = (col_b >> s) & 8'hFF;
         c = (a * (65536 - f) + b * f) >> 16;
         res |= 32'(c & 255) << s;
      end
      return res;
   endfunction

   function automatic void emit(longint x, longint y, logic [31:0] c, int cov, bit l);
      pixel_type p;
      p.px = x[15:0];
      p.py = y[15:0];
      p.color = c;
      p.cov = cov[7:0];
      p.last = l;
      pixel_queue.push_back(p);
   endfunction

   function automatic void start_axis(longint a, longint b, longint lo_clip,
                                      longint size, logic [2:0] m, longint other);
      longint lo, hi, t;
      if (a > b) begin t = a; a = b; b = t; end
      lo = a > lo_clip ? a : lo_clip;
      t = lo_clip + size - 1;
      hi = b < t ? b : t;
      if (hi < lo) begin
         mode = aagl_pkg::MODE_IDLE;
         return;
      end
      maj = lo;
      mnr = other;
      inv_len = hi - lo;
      steps = inv_len;
      pidx = 0;
      mode = steps != 0 ? m : aagl_pkg::MODE_IDLE;
      if (m == aagl_pkg::MODE_HORZ) emit(lo, other, col_a, 255, steps == 0);
      else emit(other, lo, col_a, 255, steps == 0);
   endfunction

   // compute the pixels caused by one accepted word
   function automatic void raster_word(stim_type s);
      longint x1, y1, x2, y2, t, dx, dy, dir;
      logic [31:0] old, c;
      int w;
      if (s.act == aagl_pkg::KIND_START) begin
         x1 = sx16(s.sx); y1 = sx16(s.sy); x2 = sx16(s.ex); y2 = sx16(s.ey);
         col_a = s.sc;
         col_b = s.ec;
         if (y1 > y2) begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
         end
         if (y1 == y2) begin
            start_axis(x1, x2, clip_l, clip_w, aagl_pkg::MODE_HORZ, y1);
            return;
         end
         if (x1 == x2) begin
            start_axis(y1, y2, clip_t, clip_h, aagl_pkg::MODE_VERT, x1);
            return;
         end
         dir_neg = x2 < x1;
         dx = dir_neg ? x1 - x2 : x2 - x1;
         dy = y2 - y1;
         tgt_x = x2;
         tgt_y = y2;
         err_acc = 0;
         pidx = 0;
         inv_len = (isqrt(4 * (dx * dx + dy * dy)) + 1) >> 1;
         if (dy > dx) begin
            mode = aagl_pkg::MODE_YMAJ;
            err_step = 32'(((dx << 16) / dy) << 16);
            maj = y1;
            mnr = x1;
            mnr_nx = x1 + (dir_neg ? -1 : 1);
            steps = dy - 1;
         end else begin
            mode = aagl_pkg::MODE_XMAJ;
            err_step = 32'(((dy << 16) / dx) << 16);
            maj = x1;
            mnr = y1;
            mnr_nx = y1 + 1;
            steps = dx - 1;
         end
         emit(x1, y1, col_a, 255, 0);
      end else if (mode == aagl_pkg::MODE_XMAJ || mode == aagl_pkg::MODE_YMAJ) begin
         dir = dir_neg ? -1 : 1;
         if (steps == 0) begin
            mode = aagl_pkg::MODE_IDLE;
            emit(tgt_x, tgt_y, col_b, 255, 1);
            return;
         end
         old = err_acc;
         err_acc = old + err_step;
         if (err_acc <= old) begin
            mnr = mnr_nx;
            mnr_nx += (mode == aagl_pkg::MODE_YMAJ) ? dir : 1;
         end
         maj += (mode == aagl_pkg::MODE_YMAJ) ? 1 : dir;
         c = blend(pidx, inv_len);
         pidx++;
         steps--;
         w = int'(err_acc[31:24]);
         if (mode == aagl_pkg::MODE_YMAJ) begin
            emit(mnr, maj, c, 255 - w, 0);
            emit(mnr_nx, maj, c, w, 0);
         end else begin
            emit(maj, mnr, c, 255 - w, 0);
            emit(maj, mnr_nx, c, w, 0);
         end
      end else if ((mode == aagl_pkg::MODE_HORZ || mode == aagl_pkg::MODE_VERT)
                   && steps != 0) begin
         pidx++;
         maj++;
         steps--;
         c = blend(pidx, inv_len);
         if (mode == aagl_pkg::MODE_HORZ) emit(maj, mnr, c, 255, steps == 0);
         else emit(mnr, maj, c, 255, steps == 0);
         if (steps == 0) mode = aagl_pkg::MODE_IDLE;
      end else
         mode = aagl_pkg::MODE_IDLE;
   endfunction

   // ---- output side: random stall, in-order compare
   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.px = rsp_tdata[15:0];
            got.py = rsp_tdata[31:16];
            got.color = rsp_tdata[63:32];
            got.cov = rsp_tdata[71:64];
            got.last = rsp_tlast;
            if (pixel_queue.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected pixel %h", got);
            end else begin
               want = pixel_queue.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display({"pixel mismatch: exp x=%h y=%h c=%h cov=%h l=%b",
                               " got x=%h y=%h c=%h cov=%h l=%b"},
                              want.px, want.py, want.color, want.cov, want.last,
                              got.px, got.py, got.color, got.cov, got.last);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
         // watchdog on accepted words of either side
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet <= 0;
         else quiet <= quiet + 1;
         if (quiet > WATCHDOG) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // one word, with a random gap before it; valid stays up until the next
   // gap or the drain
   task automatic send_word(stim_type s);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= s.act;
      req_tdata <= {s.ec, s.sc, s.ey, s.ex, s.sy, s.sx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (s.n_known != 0) begin
         pixel_type dummy;
         raster_word(s);       // keep predictor state
         dummy = pixel_queue.pop_back();
         pixel_queue.push_back(s.p0);
      end else
         raster_word(s);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] v);
      csr_wen <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 0;
      case (idx)
         aagl_pkg::REG_CLIP_LEFT:   clip_l = sx16(v);
         aagl_pkg::REG_CLIP_TOP:    clip_t = sx16(v);
         aagl_pkg::REG_CLIP_WIDTH:  clip_w = v;
         aagl_pkg::REG_CLIP_HEIGHT: clip_h = v;
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic stim_type mk(logic a, int x1, int y1, int x2, int y2,
                                   logic [31:0] c1, logic [31:0] c2);
      stim_type s;
      s.act = a;
      s.sx = x1[15:0]; s.sy = y1[15:0]; s.ex = x2[15:0]; s.ey = y2[15:0];
      s.sc = c1; s.ec = c2;
      s.n_known = 0;
      s.p0 = '0;
      return s;
   endfunction

   task automatic random_line();
      stim_type s;
      int x1, y1, len, k, sel;
      sel = $urandom_range(9);
      x1 = $urandom_range(65535) - 32768;
      y1 = $urandom_range(65535) - 32768;
      len = $urandom_range(12);
      s = mk(aagl_pkg::KIND_START, x1, y1, x1 + $urandom_range(2*len) - len,
             y1 + $urandom_range(2*len) - len, $urandom, $urandom);
      if (sel == 0) s.ey = s.sy;
      if (sel == 1) s.ex = s.sx;
      if (sel == 2) begin
         s.sx = 16'($urandom); s.sy = 16'($urandom);
         s.ex = 16'($urandom); s.ey = 16'($urandom);
      end
      send_word(s);
      k = (sel == 2) ? $urandom_range(4) : 2 * len + $urandom_range(2);
      if ($urandom_range(9) == 0) k = $urandom_range(k);
      repeat (k) send_word(mk(aagl_pkg::KIND_STEP, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom));
   endtask

   initial begin
      stim_type dir[$];
      stim_type s;
      clip_l = 0; clip_t = 0; clip_w = 65535; clip_h = 65535;
      mode = aagl_pkg::MODE_IDLE;
      maj = 0; mnr = 0; mnr_nx = 0; tgt_x = 0; tgt_y = 0;
      steps = 0; pidx = 0; inv_len = 0; dir_neg = 0;
      err_acc = 0; err_step = 0; col_a = 0; col_b = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: step while idle, extremes, each line kind
      dir.push_back(mk(aagl_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0));
      s = mk(aagl_pkg::KIND_START, 5, 7, 5, 7, 32'hFFFF_FFFF, 0);
      s.n_known = 1;
      s.p0 = '{16'd5, 16'd7, 32'hFFFF_FFFF, 8'd255, 1'b1}; // zero-length span
      dir.push_back(s);
      dir.push_back(mk(aagl_pkg::KIND_START, 0, 0, 4, 1, 32'h1122_3344, 32'hFF00_FF00));
      repeat (5) dir.push_back(mk(aagl_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0));
      dir.push_back(mk(aagl_pkg::KIND_START, 3, 9, 0, 0, 32'h0, 32'hFFFF_FFFF)); // swapped
      repeat (3) dir.push_back(mk(aagl_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0));
      dir.push_back(mk(aagl_pkg::KIND_START, 0, 0, 3, 3, 32'hAA, 32'h55)); // diagonal
      // horizontal, new line drops old
      dir.push_back(mk(aagl_pkg::KIND_START, 32767, 0, -32768, 0, 1, 2));
      repeat (2) dir.push_back(mk(aagl_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0));
      dir.push_back(mk(aagl_pkg::KIND_START, -32768, -32768, -32768, 4, 3, 4)); // vertical
      repeat (4) dir.push_back(mk(aagl_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0));
      dir.push_back(mk(aagl_pkg::KIND_START, -32768, -5, -32768, -1, 3, 4)); // clipped away
      dir.push_back(mk(aagl_pkg::KIND_START, 32767, 32767, -32768, -32768, 3, 4));
      foreach (dir[i]) send_word(dir[i]);
      drain();

      // random phases over several clip settings and idling mixes
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               write_reg(aagl_pkg::REG_CLIP_LEFT, 16'h8000);
               write_reg(aagl_pkg::REG_CLIP_TOP, 16'h8000);
            end
            1: begin
               write_reg(aagl_pkg::REG_CLIP_WIDTH, 16'd0);
               write_reg(aagl_pkg::REG_CLIP_HEIGHT, 16'd0);
            end
            2: begin
               write_reg(aagl_pkg::REG_CLIP_LEFT, 16'h7FFF);
               write_reg(aagl_pkg::REG_CLIP_TOP, 16'h7FFF);
               write_reg(aagl_pkg::REG_CLIP_WIDTH, 16'hFFFF);
               write_reg(aagl_pkg::REG_CLIP_HEIGHT, 16'hFFFF);
            end
            default: begin
               write_reg(aagl_pkg::REG_CLIP_LEFT, 16'($urandom));
               write_reg(aagl_pkg::REG_CLIP_TOP, 16'($urandom));
               write_reg(aagl_pkg::REG_CLIP_WIDTH,
                         16'($urandom_range(1) ? $urandom_range(20) : $urandom));
               write_reg(aagl_pkg::REG_CLIP_HEIGHT,
                         16'($urandom_range(1) ? $urandom_range(20) : $urandom));
            end
         endcase
         case (ph % 4)
            0: begin send_idle = 0;  recv_idle = 0;  end
            1: begin send_idle = 45; recv_idle = 0;  end
            2: begin send_idle = 0;  recv_idle = 45; end
            default: begin send_idle = 30; recv_idle = 30; end
         endcase
         // random lines, at times with horizontal and vertical lines near the clip window
         repeat (12) begin
            random_line();
            if ($urandom_range(3) == 0) begin
               s = mk(aagl_pkg::KIND_START, 32'(clip_l) + $urandom_range(10) - 5,
                      32'(clip_t) + $urandom_range(10) - 5, 0, 0, $urandom, $urandom);
               if ($urandom_range(1)) begin
                  s.ey = s.sy; s.ex = 16'(s.sx + $urandom_range(8));
               end else begin
                  s.ex = s.sx; s.ey = 16'(s.sy + $urandom_range(8));
               end
               send_word(s);
               repeat ($urandom_range(10))
                  send_word(mk(aagl_pkg::KIND_STEP, 0, 0, 0, 0, 0, 0));
            end
         end
         drain();
      end

      if (errors == 0 && pixel_queue.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
